// ----- rtl/core/blr_pkg.sv -----
package blr_pkg;

    // coordinate and color widths
    localparam int COORD_WIDTH = 6;
    localparam int COLOR_WIDTH = 24;

    // span of an axis: |a - b| needs one bit more than a coordinate
    localparam int SPAN_WIDTH = COORD_WIDTH + 1;
    // straight increment 2*dminor
    localparam int INCR_WIDTH = COORD_WIDTH + 2;
    // decision value and diagonal increment, signed
    localparam int ERR_WIDTH  = COORD_WIDTH + 3;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic        [COLOR_WIDTH-1:0] t_color;
    typedef logic        [SPAN_WIDTH-1:0]  t_span;
    typedef logic        [INCR_WIDTH-1:0]  t_incr;
    typedef logic signed [ERR_WIDTH-1:0]   t_err;

endpackage

// ----- rtl/core/blr_line_if.sv -----
interface blr_line_if;
    import blr_pkg::*;

    logic   valid;
    logic   ready;
    t_coord start_x;
    t_coord start_y;
    t_coord end_x;
    t_coord end_y;
    t_color color;

    modport source (
        output valid, start_x, start_y, end_x, end_y, color,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, end_x, end_y, color,
        output ready
    );

endinterface

// ----- rtl/core/blr_pixel_if.sv -----
interface blr_pixel_if;
    import blr_pkg::*;

    logic   valid;
    logic   ready;
    t_coord pixel_x;
    t_coord pixel_y;
    t_color pixel_color;
    logic   last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );

endinterface

// ----- rtl/core/bresenham_line_raster.sv -----
// Bresenham line rasterizer.
// i_line takes one line request: two signed endpoints and a 24-bit color.
// o_pixel returns the pixels of that line in walk order, one request per
// pixel, each with x, y, the color and last_pixel set on the final one.
// The walk runs along the major axis from the endpoint with the smaller
// major coordinate; a line of span d along that axis gives d + 1 pixels
// (1 to 64).
// The request is registered in the accept cycle, the setup cycle derives
// spans, increments and start point, and the first pixel is valid on the
// cycle after setup.
// Throughput: one pixel per cycle while o_pixel.ready is high, set by the
// single error-term adder that is reused for every step of the walk;
// i_line.ready stays low from accept until the last pixel is taken.
// A stall on o_pixel holds the current pixel and all walk state unchanged.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// any line in progress.
module bresenham_line_raster (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blr_line_if.sink    i_line,
    blr_pixel_if.source o_pixel
);
    import blr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SETUP = 3'b010,
        S_WALK  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // captured request
    t_coord r_x0, r_y0, r_x1, r_y1;
    t_color r_color;

    // walk state
    t_coord r_major_pos, n_major_pos;
    t_coord r_minor_pos, n_minor_pos;
    t_coord r_major_end, n_major_end;
    t_err   r_err,       n_err;
    t_incr  r_incr_str,  n_incr_str;
    t_err   r_incr_diag, n_incr_diag;
    logic   r_minor_neg, n_minor_neg;
    logic   r_steep,     n_steep;

    logic   w_line_acc;
    logic   w_pix_acc;
    logic   w_last;

    // setup datapath
    logic signed [SPAN_WIDTH-1:0] w_dx_s, w_dy_s;
    t_span  w_dx, w_dy, w_dmajor, w_dminor;
    logic   w_steep, w_swap;
    t_coord w_ma0, w_mi0, w_ma1, w_mi1;
    t_coord w_sa0, w_si0, w_sa1, w_si1;
    t_err   w_min_e, w_maj_e;

    // shared walk unit
    t_err   w_err_add;
    t_err   w_err_step;
    t_coord w_minor_step;

    assign w_line_acc = i_line.valid && i_line.ready;
    assign w_pix_acc  = o_pixel.valid && o_pixel.ready;
    assign w_last     = r_major_pos >= r_major_end;

    // handshakes and pixel payload
    assign i_line.ready        = (r_state == S_IDLE);
    assign o_pixel.valid       = (r_state == S_WALK);
    assign o_pixel.pixel_x     = r_steep ? r_minor_pos : r_major_pos;
    assign o_pixel.pixel_y     = r_steep ? r_major_pos : r_minor_pos;
    assign o_pixel.pixel_color = r_color;
    assign o_pixel.last_pixel  = w_last;

    // axis spans and octant selection
    always_comb begin
        w_dx_s   = SPAN_WIDTH'(r_x1) - SPAN_WIDTH'(r_x0);
        w_dy_s   = SPAN_WIDTH'(r_y1) - SPAN_WIDTH'(r_y0);
        w_dx     = w_dx_s[SPAN_WIDTH-1] ? t_span'(-w_dx_s) : t_span'(w_dx_s);
        w_dy     = w_dy_s[SPAN_WIDTH-1] ? t_span'(-w_dy_s) : t_span'(w_dy_s);
        w_steep  = w_dy > w_dx;
        w_dmajor = w_steep ? w_dy : w_dx;
        w_dminor = w_steep ? w_dx : w_dy;
        w_ma0    = w_steep ? r_y0 : r_x0;
        w_mi0    = w_steep ? r_x0 : r_y0;
        w_ma1    = w_steep ? r_y1 : r_x1;
        w_mi1    = w_steep ? r_x1 : r_y1;
        // walk from the smaller major coordinate, first endpoint on a tie
        w_swap   = w_ma1 < w_ma0;
        w_sa0    = w_swap ? w_ma1 : w_ma0;
        w_si0    = w_swap ? w_mi1 : w_mi0;
        w_sa1    = w_swap ? w_ma0 : w_ma1;
        w_si1    = w_swap ? w_mi0 : w_mi1;
        w_min_e  = signed'(ERR_WIDTH'(w_dminor));
        w_maj_e  = signed'(ERR_WIDTH'(w_dmajor));
    end

    // error term update and minor step, one per pixel
    always_comb begin
        w_err_add    = r_err[ERR_WIDTH-1] ? signed'(ERR_WIDTH'(r_incr_str)) : r_incr_diag;
        w_err_step   = r_err + w_err_add;
        w_minor_step = r_minor_neg ? (r_minor_pos - t_coord'(1))
                                   : (r_minor_pos + t_coord'(1));
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_major_pos = r_major_pos;
        n_minor_pos = r_minor_pos;
        n_major_end = r_major_end;
        n_err       = r_err;
        n_incr_str  = r_incr_str;
        n_incr_diag = r_incr_diag;
        n_minor_neg = r_minor_neg;
        n_steep     = r_steep;
        case (r_state)
            S_IDLE: begin
                if (w_line_acc) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_steep     = w_steep;
                n_major_pos = w_sa0;
                n_minor_pos = w_si0;
                n_major_end = w_sa1;
                n_minor_neg = w_si1 < w_si0;
                n_incr_str  = {w_dminor, 1'b0};
                n_incr_diag = (w_min_e - w_maj_e) <<< 1;
                n_err       = (w_min_e <<< 1) - w_maj_e;
                n_state     = S_WALK;
            end
            S_WALK: begin
                if (w_pix_acc) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_major_pos = r_major_pos + t_coord'(1);
                        n_err       = w_err_step;
                        if (!r_err[ERR_WIDTH-1]) begin
                            n_minor_pos = w_minor_step;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture and walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x0        <= '0;
            r_y0        <= '0;
            r_x1        <= '0;
            r_y1        <= '0;
            r_color     <= '0;
            r_major_pos <= '0;
            r_minor_pos <= '0;
            r_major_end <= '0;
            r_err       <= '0;
            r_incr_str  <= '0;
            r_incr_diag <= '0;
            r_minor_neg <= 1'b0;
            r_steep     <= 1'b0;
        end else begin
            if (w_line_acc) begin
                r_x0    <= i_line.start_x;
                r_y0    <= i_line.start_y;
                r_x1    <= i_line.end_x;
                r_y1    <= i_line.end_y;
                r_color <= i_line.color;
            end
            r_major_pos <= n_major_pos;
            r_minor_pos <= n_minor_pos;
            r_major_end <= n_major_end;
            r_err       <= n_err;
            r_incr_str  <= n_incr_str;
            r_incr_diag <= n_incr_diag;
            r_minor_neg <= n_minor_neg;
            r_steep     <= n_steep;
        end
    end

    // a non-final pixel taken advances the major axis by exactly one
    a_major_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel.valid && o_pixel.ready && !o_pixel.last_pixel)
        |=> (r_major_pos == $past(r_major_pos) + t_coord'(1)))
        else $error("major axis did not advance by one");

    // the walk never overshoots its end point
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_major_pos <= r_major_end))
        else $error("walk passed the line end");

    // the minor axis moves by at most one per pixel
    a_minor_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel.valid && o_pixel.ready && !o_pixel.last_pixel)
        |=> ((r_minor_pos == $past(r_minor_pos))
          || (r_minor_pos == $past(r_minor_pos) + t_coord'(1))
          || (r_minor_pos == $past(r_minor_pos) - t_coord'(1))))
        else $error("minor axis jumped");

    // a stalled pixel keeps the whole walk state
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel.valid && !o_pixel.ready)
        |=> ($stable(r_major_pos) && $stable(r_minor_pos) && $stable(r_err)
          && o_pixel.valid))
        else $error("walk state changed during stall");

    // a new request is taken only after the previous line has finished
    a_accept_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel.valid && o_pixel.ready && o_pixel.last_pixel)
        |=> (i_line.ready && !o_pixel.valid))
        else $error("block not idle after last pixel");

endmodule

// ----- bench/tb_bresenham_line_raster.sv -----
`timescale 1ns / 100ps

module tb_bresenham_line_raster;
    import blr_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_color color;
        logic   last;
    } t_pixel;

    logic i_clk;
    logic i_rst_n;

    blr_line_if  line_bus ();
    blr_pixel_if pixel_bus ();

    bresenham_line_raster u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (line_bus),
        .o_pixel (pixel_bus)
    );

    // pixels still owed by the block, oldest first
    t_pixel expected_pixels[$];

    int  n_errors;
    int  lines_sent;
    int  steep_lines;
    int  longest_line;
    int  pixels_checked;
    bit  source_idling;
    bit  sink_idling;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(0, 3);
    endfunction

    // coordinate near a base point, kept on the grid
    function automatic t_coord near_coord(input t_coord base, input int reach);
        int v;
        v = int'(base) + $urandom_range(0, 2 * reach) - reach;
        if (v < -32)
            v = -32;
        if (v > 31)
            v = 31;
        return t_coord'(v);
    endfunction

    // walk the line along its major axis and queue every pixel it covers
    function automatic void trace_line(input t_coord sx, input t_coord sy,
                                       input t_coord ex, input t_coord ey,
                                       input t_color c);
        int     dx, dy, dmajor, dminor;
        int     maj0, min0, maj1, min1, tmp;
        int     major_at, minor_at;
        t_err   err, step_straight, step_diag;
        bit     steep, minor_down, done;
        t_pixel p;
        dx = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
        dy = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
        steep = dy > dx;
        if (steep) begin
            maj0 = sy; min0 = sx; maj1 = ey; min1 = ex;
            dmajor = dy; dminor = dx;
        end else begin
            maj0 = sx; min0 = sy; maj1 = ex; min1 = ey;
            dmajor = dx; dminor = dy;
        end
        // start from the smaller major coordinate
        if (maj1 < maj0) begin
            tmp = maj0; maj0 = maj1; maj1 = tmp;
            tmp = min0; min0 = min1; min1 = tmp;
        end
        minor_down    = min1 < min0;
        step_straight = t_err'(2 * dminor);
        step_diag     = t_err'(2 * (dminor - dmajor));
        err           = t_err'(2 * dminor - dmajor);
        major_at      = maj0;
        minor_at      = min0;
        done          = 1'b0;
        while (!done) begin
            done    = major_at >= maj1;
            p.x     = steep ? t_coord'(minor_at) : t_coord'(major_at);
            p.y     = steep ? t_coord'(major_at) : t_coord'(minor_at);
            p.color = c;
            p.last  = done;
            expected_pixels.push_back(p);
            if (!done) begin
                major_at++;
                if (err < 0) begin
                    err = err + step_straight;
                end else begin
                    minor_at = minor_down ? minor_at - 1 : minor_at + 1;
                    err = err + step_diag;
                end
            end
        end
        if (steep)
            steep_lines++;
        if (dmajor + 1 > longest_line)
            longest_line = dmajor + 1;
    endfunction

    // send one line request; starts and ends on a rising edge
    task automatic send_line(input t_coord sx, input t_coord sy,
                             input t_coord ex, input t_coord ey,
                             input t_color c);
        int gap;
        gap = source_idling ? pick_gap() : 0;
        if (gap > 0) begin
            line_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        line_bus.valid   <= 1'b1;
        line_bus.start_x <= sx;
        line_bus.start_y <= sy;
        line_bus.end_x   <= ex;
        line_bus.end_y   <= ey;
        line_bus.color   <= c;
        do @(posedge i_clk); while (!line_bus.ready);
        trace_line(sx, sy, ex, ey, c);
        lines_sent++;
    endtask

    // hold off the sender until the block has returned every pixel
    task automatic wait_all_pixels();
        line_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    // single points, full-span axis lines, the two long diagonals and two short lines
    task automatic test_extremes();
        source_idling = 1'b0;
        sink_idling   = 1'b0;
        send_line(6'sd0, 6'sd0, 6'sd0, 6'sd0, 24'h000000);
        send_line(-6'sd32, -6'sd32, -6'sd32, -6'sd32, 24'hFFFFFF);
        send_line(6'sd31, 6'sd31, 6'sd31, 6'sd31, 24'hA5A5A5);
        send_line(-6'sd32, 6'sd5, 6'sd31, 6'sd5, 24'h5A5A5A);
        send_line(6'sd31, -6'sd3, -6'sd32, -6'sd3, 24'h123456);
        send_line(6'sd4, -6'sd32, 6'sd4, 6'sd31, 24'hFEDCBA);
        send_line(-6'sd6, 6'sd31, -6'sd6, -6'sd32, 24'h800001);
        send_line(-6'sd32, -6'sd32, 6'sd31, 6'sd31, 24'h7FFFFE);
        send_line(6'sd31, -6'sd32, -6'sd32, 6'sd31, 24'hFFFFFF);
        send_line(6'sd3, 6'sd3, -6'sd5, -6'sd5, 24'h00FF00);
        send_line(-6'sd4, 6'sd7, 6'sd2, 6'sd1, 24'h0000FF);
    endtask

    // one line into each of the eight octants, four shallow and four steep, with idling
    task automatic test_octants();
        source_idling = 1'b1;
        sink_idling   = 1'b1;
        send_line(6'sd0, 6'sd0, 6'sd20, 6'sd7, 24'h111111);
        send_line(6'sd0, 6'sd0, -6'sd20, 6'sd7, 24'h222222);
        send_line(6'sd0, 6'sd0, 6'sd20, -6'sd7, 24'h333333);
        send_line(6'sd0, 6'sd0, -6'sd20, -6'sd7, 24'h444444);
        send_line(6'sd1, -6'sd2, 6'sd8, 6'sd18, 24'h555555);
        send_line(6'sd1, -6'sd2, -6'sd6, 6'sd18, 24'h666666);
        send_line(-6'sd1, 6'sd2, 6'sd6, -6'sd18, 24'h777777);
        send_line(-6'sd1, 6'sd2, -6'sd8, -6'sd18, 24'h888888);
    endtask

    // random lines: mostly short ones, some across the grid, some aligned
    task automatic test_random_lines(input int count);
        t_coord sx, sy, ex, ey;
        int     kind, d;
        for (int i = 0; i < count; i++) begin
            sx   = t_coord'($urandom);
            sy   = t_coord'($urandom);
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                ex = near_coord(sx, 8);
                ey = near_coord(sy, 8);
            end else if (kind < 9) begin
                ex = t_coord'($urandom);
                ey = t_coord'($urandom);
            end else begin
                d  = $urandom_range(0, 15);
                ex = near_coord(sx, d);
                ey = ($urandom_range(0, 2) == 0) ? sy :
                     t_coord'(int'(sy) + ((int'(ex) > int'(sx)) ?
                                          int'(ex) - int'(sx) : int'(sx) - int'(ex)));
                if (int'(ey) != int'(sy) && ($urandom_range(0, 1) == 0))
                    ey = sy;
            end
            send_line(sx, sy, ex, ey, t_color'($urandom));
        end
    endtask

    // drain completely, then send back to back with the sink always ready
    task automatic test_drain_then_burst(input int count);
        source_idling = 1'b1;
        sink_idling   = 1'b1;
        wait_all_pixels();
        source_idling = 1'b0;
        sink_idling   = 1'b0;
        test_random_lines(count);
        wait_all_pixels();
        source_idling = 1'b1;
        sink_idling   = 1'b1;
    endtask

    // sink side ready pattern: runs of ready broken by stalls
    initial begin
        int   hold;
        logic lvl;
        hold = 0;
        lvl  = 1'b0;
        pixel_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (!sink_idling) begin
                lvl = 1'b1;
            end else begin
                lvl  = ($urandom_range(0, 3) != 0);
                hold = lvl ? $urandom_range(0, 8) : pick_gap();
            end
            pixel_bus.ready <= lvl;
        end
    end

    task automatic report_mismatch(input string field, input int want, input int got);
        n_errors++;
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, field, want, got);
    endtask

    // compare each returned pixel with the oldest one owed
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && pixel_bus.valid && pixel_bus.ready) begin
            pixels_checked++;
            if (expected_pixels.size() == 0) begin
                n_errors++;
                $display("%0t unexpected pixel x=%0d y=%0d color=%06h last=%0b", $time,
                         pixel_bus.pixel_x, pixel_bus.pixel_y,
                         pixel_bus.pixel_color, pixel_bus.last_pixel);
            end else begin
                want = expected_pixels.pop_front();
                if (pixel_bus.pixel_x !== want.x)
                    report_mismatch("pixel_x", want.x, pixel_bus.pixel_x);
                if (pixel_bus.pixel_y !== want.y)
                    report_mismatch("pixel_y", want.y, pixel_bus.pixel_y);
                if (pixel_bus.pixel_color !== want.color)
                    report_mismatch("pixel_color", want.color, pixel_bus.pixel_color);
                if (pixel_bus.last_pixel !== want.last)
                    report_mismatch("last_pixel", want.last, pixel_bus.last_pixel);
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((line_bus.valid && line_bus.ready) || (pixel_bus.valid && pixel_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t timeout: no request moved for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    // main sequence
    initial begin
        n_errors       = 0;
        lines_sent     = 0;
        steep_lines    = 0;
        longest_line   = 0;
        pixels_checked = 0;
        source_idling  = 1'b0;
        sink_idling    = 1'b0;
        i_rst_n          <= 1'b0;
        line_bus.valid   <= 1'b0;
        line_bus.start_x <= '0;
        line_bus.start_y <= '0;
        line_bus.end_x   <= '0;
        line_bus.end_y   <= '0;
        line_bus.color   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_octants();
        test_random_lines(220);
        test_drain_then_burst(100);
        test_random_lines(120);

        line_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d lines (%0d steep, longest %0d pixels), %0d pixels checked",
                 lines_sent, steep_lines, longest_line, pixels_checked);
        $display("all octants, single points, full-span lines, stalls and back-to-back");
        if (n_errors == 0 && expected_pixels.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d pixels never returned", n_errors,
                     expected_pixels.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/blr_pkg.sv
rtl/core/blr_line_if.sv
rtl/core/blr_pixel_if.sv
rtl/core/bresenham_line_raster.sv
bench/tb_bresenham_line_raster.sv
